// ===== rtl/core/mtvb_pkg.sv =====
`default_nettype none
package mtvb_pkg;

  localparam int FracBits = 16;
  localparam int AccW     = 40;
  localparam int CompW    = 32;
  localparam int NumComp  = 9;
  localparam int WeightW  = 18;
  localparam int OutW     = 18;
  localparam int InDataW  = 312;
  localparam int OutDataW = 208;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLEND_RULE = 3'd0,
    CFG_POS_EN     = 3'd1,
    CFG_NORM_EN    = 3'd2,
    CFG_TAN_EN     = 3'd3
  } cfg_idx_e;

endpackage
`default_nettype wire

// ===== rtl/core/morph_target_vertex_blend_top.sv =====
// channel | dir | handshake                  | contents
// s_axis  | in  | s_axis_tvalid/tready       | tuser mode, tlast last_item, tdata weight + 9 comps
// m_axis  | out | m_axis_tvalid/tready       | tdata blended position, unit normal, unit tangent
// cfg     | in  | cfg_we_i                   | cfg_idx_i register index, cfg_data_i bit 0
//
// a neutral item is stored directly, a shape item with non-zero weight is blended: one
// shared 34x32 multiplier serves the nine multiply-accumulates, multiply and add in turn.
// an item marked last then normalises normal and tangent on the same multiplier, a
// one-bit-per-cycle square root and a restoring divider.
// reset clears accumulators, shape flag and output valid, sets config defaults; neutral store is not cleared.
// a waiting result holds the block only at the moment a new result must be loaded.
`default_nettype none
module morph_target_vertex_blend_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // weight, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tan_x, tan_y, tan_z
  input  logic [mtvb_pkg::InDataW-1:0]  s_axis_tdata,
  // mode
  input  logic [0:0]                    s_axis_tuser,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z,
  // out_tan_x, out_tan_y, out_tan_z
  output logic [mtvb_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [mtvb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mtvb_pkg::CfgDataW-1:0] cfg_data_i
);
  import mtvb_pkg::*;

  localparam int WClW = FracBits + 1;
  localparam int DvdW = 31 + FracBits + 1;
  localparam int RemW = 34;
  localparam int CntW = $clog2(FracBits + 2);
  localparam int SumW = 68;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ADD, ST_NLOAD, ST_SHIFT, ST_SQM, ST_SQA,
    ST_SQRT, ST_DIVI, ST_DIV, ST_OUT
  } state_e;

  state_e state_q;

  logic                   rule_q, pos_en_q, norm_en_q, tan_en_q;
  logic [CompW-1:0]       item_q [NumComp];
  logic [CompW-1:0]       neut_q [NumComp];
  logic signed [AccW-1:0] acc_q  [NumComp];
  logic                   used_q, last_q;
  logic [WClW-1:0]        w_q;
  logic [3:0]             idx_q;
  logic                   vec_q;
  logic signed [65:0]     prod_q;
  logic [AccW-1:0]        mag_q [3];
  logic                   neg_q [3];
  logic [63:0]            sum_q, res_q, bit_q;
  logic [RemW-1:0]        rem_q;
  logic [FracBits:0]      low_q;
  logic [FracBits:0]      quo_q;
  logic [CntW-1:0]        cnt_q;
  logic [OutW-1:0]        nrm_q [3];
  logic [OutW-1:0]        tng_q [3];
  logic                   m_valid_q;
  logic [OutDataW-1:0]    m_data_q;

  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [SumW-1:0] x);
    logic signed [SumW-1:0] hi, lo;
    hi = (SumW'(1) <<< (AccW - 1)) - SumW'(1);
    lo = -hi - SumW'(1);
    if (x > hi) return AccW'(hi);
    if (x < lo) return AccW'(lo);
    return AccW'(x);
  endfunction

  function automatic logic [CompW-1:0] sat32(input logic signed [AccW-1:0] x);
    logic signed [AccW-1:0] hi, lo;
    hi = (AccW'(1) <<< (CompW - 1)) - AccW'(1);
    lo = -hi - AccW'(1);
    if (x > hi) return CompW'(hi);
    if (x < lo) return CompW'(lo);
    return CompW'(x);
  endfunction

  // single read address into the component registers
  logic [3:0]             elem;
  logic [3:0]             rd_addr;
  logic [CompW-1:0]       rd_item, rd_neut;
  logic signed [AccW-1:0] rd_acc;

  assign elem    = 4'd3 + (vec_q ? 4'd3 : 4'd0) + {2'b00, idx_q[1:0]};
  assign rd_addr = (state_q == ST_NLOAD) ? elem : idx_q;
  assign rd_item = item_q[rd_addr];
  assign rd_neut = neut_q[rd_addr];
  assign rd_acc  = acc_q[rd_addr];

  // shared multiplier
  logic signed [32:0] diff;
  logic [30:0]        sq_op;
  logic signed [33:0] mult_a;
  logic signed [31:0] mult_b;
  logic signed [65:0] prod_d;

  assign diff  = rule_q ? 33'($signed(rd_item))
                        : 33'($signed(rd_item)) - 33'($signed(rd_neut));
  assign sq_op = mag_q[idx_q[1:0]][30:0];
  assign mult_a = (state_q == ST_SQM) ? $signed({3'b000, sq_op}) : 34'(diff);
  assign mult_b = (state_q == ST_SQM) ? $signed({1'b0, sq_op})
                                      : $signed({{(32-WClW){1'b0}}, w_q});
  assign prod_d = 66'(mult_a) * 66'(mult_b);

  // rounded weighted term plus accumulator, plus the neutral normal or tangent component when the blend rule is 0
  logic signed [65:0]     term;
  logic signed [SumW-1:0] add_n, acc_sum;

  assign term    = (prod_q + (66'sd1 <<< (FracBits - 1))) >>> FracBits;
  assign add_n   = (!rule_q && idx_q >= 4'd3) ? SumW'($signed(rd_neut)) : '0;
  assign acc_sum = SumW'(rd_acc) + SumW'(term) + add_n;

  // magnitude of the normalised source
  logic signed [AccW-1:0] nsrc;
  assign nsrc = used_q ? rd_acc : AccW'($signed(rd_neut));

  logic any_hi, any_b30, all_zero;
  always_comb begin
    any_hi   = 1'b0;
    any_b30  = 1'b0;
    all_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      any_hi   = any_hi | (|mag_q[i][AccW-1:31]);
      any_b30  = any_b30 | mag_q[i][30];
      all_zero = all_zero & (mag_q[i] == '0);
    end
  end

  logic [63:0]       trial;
  logic [DvdW-1:0]   dvd;
  logic [RemW-1:0]   rem2;
  logic              ge;
  logic [FracBits:0] q_fin;
  logic [OutW-1:0]   q_ext, q_signed;

  assign trial    = res_q + bit_q;
  assign dvd      = (DvdW'(sq_op) << FracBits) + DvdW'(res_q[32:1]);
  assign rem2     = {rem_q[RemW-2:0], low_q[FracBits]};
  assign ge       = rem2 >= RemW'(res_q[32:0]);
  assign q_fin    = {quo_q[FracBits-1:0], ge};
  assign q_ext    = OutW'(q_fin);
  assign q_signed = neg_q[idx_q[1:0]] ? (~q_ext + OutW'(1)) : q_ext;

  logic signed [WeightW-1:0] win;
  logic [WClW-1:0]           wcl;
  assign win = s_axis_tdata[WeightW-1:0];
  always_comb begin
    if (win < 0) wcl = '0;
    else if (win > WeightW'(1 << FracBits)) wcl = WClW'(1 << FracBits);
    else wcl = WClW'(win);
  end

  logic [OutDataW-1:0] out_pack;
  always_comb begin
    out_pack = '0;
    for (int i = 0; i < 3; i++) begin
      out_pack[CompW*i +: CompW] = pos_en_q ? sat32(acc_q[i]) : '0;
      out_pack[3*CompW + OutW*i +: OutW]     = norm_en_q ? nrm_q[i] : '0;
      out_pack[3*CompW + OutW*(3+i) +: OutW] = tan_en_q ? tng_q[i] : '0;
    end
  end

  logic s_xfer;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rule_q    <= 1'b0;
      pos_en_q  <= 1'b1;
      norm_en_q <= 1'b1;
      tan_en_q  <= 1'b0;
      used_q    <= 1'b0;
      m_valid_q <= 1'b0;
      idx_q     <= '0;
      vec_q     <= 1'b0;
      cnt_q     <= '0;
      for (int i = 0; i < NumComp; i++) acc_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BLEND_RULE: rule_q    <= cfg_data_i[0];
          CFG_POS_EN:     pos_en_q  <= cfg_data_i[0];
          CFG_NORM_EN:    norm_en_q <= cfg_data_i[0];
          CFG_TAN_EN:     tan_en_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (s_xfer) begin
            last_q <= s_axis_tlast;
            idx_q  <= '0;
            vec_q  <= 1'b0;
            if (!s_axis_tuser[0]) begin
              for (int i = 0; i < NumComp; i++) begin
                neut_q[i] <= s_axis_tdata[WeightW + CompW*i +: CompW];
                acc_q[i]  <= (i < 3 || rule_q)
                           ? AccW'($signed(s_axis_tdata[WeightW + CompW*i +: CompW])) : '0;
              end
              used_q  <= 1'b0;
              state_q <= s_axis_tlast ? ST_NLOAD : ST_IDLE;
            end else begin
              for (int i = 0; i < NumComp; i++)
                item_q[i] <= s_axis_tdata[WeightW + CompW*i +: CompW];
              w_q <= wcl;
              if (wcl != '0) begin
                used_q  <= 1'b1;
                state_q <= ST_MUL;
              end else begin
                state_q <= s_axis_tlast ? ST_NLOAD : ST_IDLE;
              end
            end
          end
        end
        ST_MUL: begin
          prod_q  <= prod_d;
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          acc_q[idx_q] <= sat_acc(acc_sum);
          if (idx_q == 4'(NumComp - 1)) begin
            idx_q   <= '0;
            state_q <= last_q ? ST_NLOAD : ST_IDLE;
          end else begin
            idx_q   <= idx_q + 4'd1;
            state_q <= ST_MUL;
          end
        end
        ST_NLOAD: begin
          neg_q[idx_q[1:0]] <= nsrc[AccW-1];
          mag_q[idx_q[1:0]] <= nsrc[AccW-1] ? AccW'(-nsrc) : AccW'(nsrc);
          if (idx_q == 4'd2) begin
            idx_q   <= '0;
            state_q <= ST_SHIFT;
          end else begin
            idx_q <= idx_q + 4'd1;
          end
        end
        ST_SHIFT: begin
          if (all_zero) begin
            for (int i = 0; i < 3; i++) begin
              if (vec_q) tng_q[i] <= '0;
              else nrm_q[i] <= '0;
            end
            vec_q   <= 1'b1;
            state_q <= vec_q ? ST_OUT : ST_NLOAD;
          end else if (any_hi) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
          end else if (!any_b30) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
          end else begin
            sum_q   <= '0;
            state_q <= ST_SQM;
          end
        end
        ST_SQM: begin
          prod_q  <= prod_d;
          state_q <= ST_SQA;
        end
        ST_SQA: begin
          sum_q <= sum_q + prod_q[63:0];
          if (idx_q == 4'd2) begin
            idx_q   <= '0;
            res_q   <= '0;
            bit_q   <= 64'd1 << 62;
            state_q <= ST_SQRT;
          end else begin
            idx_q   <= idx_q + 4'd1;
            state_q <= ST_SQM;
          end
        end
        ST_SQRT: begin
          // one result bit per cycle
          if (sum_q >= trial) begin
            sum_q <= sum_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) state_q <= ST_DIVI;
        end
        ST_DIVI: begin
          rem_q   <= RemW'(dvd[DvdW-1:FracBits+1]);
          low_q   <= dvd[FracBits:0];
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= ge ? rem2 - RemW'(res_q[32:0]) : rem2;
          low_q <= low_q << 1;
          quo_q <= q_fin;
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(FracBits)) begin
            if (vec_q) tng_q[idx_q[1:0]] <= q_signed;
            else nrm_q[idx_q[1:0]] <= q_signed;
            if (idx_q == 4'd2) begin
              idx_q   <= '0;
              vec_q   <= 1'b1;
              state_q <= vec_q ? ST_OUT : ST_NLOAD;
            end else begin
              idx_q   <= idx_q + 4'd1;
              state_q <= ST_DIVI;
            end
          end
        end
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= out_pack;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mtvb_checker.sv =====
`default_nettype none
module mtvb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [0:0]                    s_axis_tuser,
  input logic                          s_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mtvb_pkg::OutDataW-1:0] m_axis_tdata
);

  logic s_xfer;
  assign s_xfer = s_axis_tvalid && s_axis_tready;

  // a neutral item that does not end the vertex leaves the input ready in the next cycle
  a_neutral_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && !s_axis_tlast && !s_axis_tuser[0] |=> s_axis_tready)
    else $error("neutral item did not return to ready");

  // the end of a vertex always starts normalisation
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && s_axis_tlast |=> !s_axis_tready)
    else $error("ready right after last item");

  a_no_result_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && !s_axis_tlast |=> !$rose(m_axis_tvalid))
    else $error("result after item not marked last");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind morph_target_vertex_blend_top mtvb_checker u_mtvb_checker (.*);
`default_nettype wire
